/* hdl/lcat_pkg.sv */
// ----------------------------------------------------------------------------
// lcat_pkg
// Shared types, widths and constants for the load-cell average and tare block.
// ----------------------------------------------------------------------------
package lcat_pkg;

  localparam int unsigned SAMPLE_W      = 24;
  localparam int unsigned WEIGHT_W      = 26;
  localparam int unsigned GAIN_W        = 32;
  localparam int unsigned SHORT_LEN_DEF = 10;
  localparam int unsigned LONG_LEN_DEF  = 100;

  // About 2^24 / 213.34278867748 in unsigned Q24
  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd78640;

  // Register stages in the constant divider
  localparam int unsigned CDIV_LAT = 5;

  // Result queue; deeper than the accept-to-result latency
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TARE   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [SAMPLE_W-1:0] raw_count;
  } in_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_q8;
    logic signed [SAMPLE_W-1:0] short_average;
    logic signed [SAMPLE_W-1:0] long_average;
  } out_t;

  // Control travelling alongside the data path
  typedef struct packed {
    logic  vld;
    kind_e kind;
  } pipe_t;

  // Running sum of len signed samples
  function automatic int unsigned total_width(int unsigned len);
    return SAMPLE_W + $clog2(len);
  endfunction

  function automatic int unsigned addr_width(int unsigned len);
    return (len > 1) ? $clog2(len) : 1;
  endfunction

endpackage

/* hdl/lcat_ring.sv */
// ----------------------------------------------------------------------------
// lcat_ring
// Ring window memory with running sum: read the slot at accept, write back
// the new sample and update the sum in the cycle after.
// ----------------------------------------------------------------------------
module lcat_ring #(
  parameter int unsigned LEN = lcat_pkg::SHORT_LEN_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              wr_i,
  input  logic [lcat_pkg::SAMPLE_W-1:0]                     sample_i,
  output logic signed [lcat_pkg::total_width(LEN)-1:0]      total_o
);
  import lcat_pkg::*;

  localparam int unsigned AW = addr_width(LEN);
  localparam int unsigned TW = total_width(LEN);

  logic [SAMPLE_W-1:0]      mem [LEN];
  logic [LEN-1:0]           written_q;
  logic [AW-1:0]            ptr_q, ptr_d;
  logic                     s1_wr_q;
  logic [AW-1:0]            s1_addr_q;
  logic [SAMPLE_W-1:0]      s1_smp_q;
  logic [SAMPLE_W-1:0]      rd_q;
  logic                     rv_q;
  logic                     fwd_q;
  logic [SAMPLE_W-1:0]      fwd_smp_q;
  logic signed [TW-1:0]     total_q, total_d;
  logic [SAMPLE_W-1:0]      old_smp;
  logic signed [TW-1:0]     new_ext, old_ext;

  assign ptr_d = (ptr_q == AW'(LEN - 1)) ? '0 : ptr_q + AW'(1);

  // Window memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (s1_wr_q) begin
      mem[s1_addr_q] <= s1_smp_q;
    end
    if (wr_i) begin
      rd_q      <= mem[ptr_q];
      s1_addr_q <= ptr_q;
      s1_smp_q  <= sample_i;
      fwd_smp_q <= s1_smp_q;
    end
  end

  // Never-written slots read as zero; forward a write-back to the same slot
  assign old_smp = fwd_q ? fwd_smp_q : (rv_q ? rd_q : '0);
  assign new_ext = TW'($signed(s1_smp_q));
  assign old_ext = TW'($signed(old_smp));
  assign total_d = total_q + new_ext - old_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      ptr_q     <= '0;
      s1_wr_q   <= 1'b0;
      rv_q      <= 1'b0;
      fwd_q     <= 1'b0;
      total_q   <= '0;
    end else begin
      s1_wr_q <= wr_i;
      if (wr_i) begin
        ptr_q <= ptr_d;
        rv_q  <= written_q[ptr_q];
        fwd_q <= s1_wr_q && (s1_addr_q == ptr_q);
      end
      if (s1_wr_q) begin
        written_q[s1_addr_q] <= 1'b1;
        total_q              <= total_d;
      end
    end
  end

  assign total_o = total_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= AW'(LEN - 1))
    else $error("ring pointer beyond window");

endmodule

/* hdl/lcat_cdiv.sv */
// ----------------------------------------------------------------------------
// lcat_cdiv
// Signed division of a window sum by the window length, truncating toward
// zero: reciprocal multiply, then one correction step.
// ----------------------------------------------------------------------------
module lcat_cdiv #(
  parameter int unsigned LEN = lcat_pkg::SHORT_LEN_DEF
) (
  input  logic                                          clk_i,
  input  logic signed [lcat_pkg::total_width(LEN)-1:0]  total_i,
  output logic signed [lcat_pkg::SAMPLE_W-1:0]          avg_o
);
  import lcat_pkg::*;

  localparam int unsigned TW = total_width(LEN);
  localparam int unsigned RW = TW + 1;
  localparam int unsigned PW = TW + RW;
  localparam int unsigned QW = SAMPLE_W;
  // floor(2^TW / LEN): estimate is low by at most one
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << TW) / LEN);
  localparam logic [TW-1:0] LEN_W = TW'(LEN);

  logic          neg1_q, neg2_q, neg3_q, neg4_q;
  logic [TW-1:0] mag1_q, mag2_q, mag3_q;
  logic [PW-1:0] prod_q;
  logic [QW-1:0] qe_q, q_q;
  logic [TW-1:0] back;
  logic [TW-1:0] rem;
  logic [QW-1:0] q_d;
  logic signed [SAMPLE_W-1:0] avg_q;

  assign back = TW'(qe_q) * LEN_W;
  assign rem  = mag3_q - back;
  assign q_d  = qe_q + QW'(rem >= LEN_W);

  always_ff @(posedge clk_i) begin
    neg1_q <= total_i[TW-1];
    mag1_q <= total_i[TW-1] ? TW'(-total_i) : TW'(total_i);

    neg2_q <= neg1_q;
    mag2_q <= mag1_q;
    prod_q <= PW'(mag1_q) * PW'(RECIP);

    neg3_q <= neg2_q;
    mag3_q <= mag2_q;
    qe_q   <= prod_q[TW +: QW];

    neg4_q <= neg3_q;
    q_q    <= q_d;

    avg_q  <= neg4_q ? $signed(-q_q) : $signed(q_q);
  end

  assign avg_o = avg_q;

endmodule

/* hdl/lcat_weight.sv */
// ----------------------------------------------------------------------------
// lcat_weight
// Zero offset register and tared weight: (short - zero) * gain >>> 16,
// saturated to the result width.
// ----------------------------------------------------------------------------
module lcat_weight (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcat_pkg::pipe_t               ctl_i,
  input  logic signed [lcat_pkg::SAMPLE_W-1:0] short_avg_i,
  input  logic signed [lcat_pkg::SAMPLE_W-1:0] long_avg_i,
  input  logic [lcat_pkg::GAIN_W-1:0]   gain_i,
  output logic                          vld_o,
  output lcat_pkg::out_t                res_o
);
  import lcat_pkg::*;

  localparam int unsigned DW = SAMPLE_W + 1;
  localparam int unsigned PW = DW + GAIN_W + 1;
  localparam int unsigned SW = PW - 16;
  localparam logic signed [SW-1:0] W_MAX = SW'(33554431);
  localparam logic signed [SW-1:0] W_MIN = -SW'(33554432);

  logic signed [SAMPLE_W-1:0] zero_q;
  logic                       v1_q, v2_q, v3_q;
  logic signed [SAMPLE_W-1:0] sa1_q, la1_q, sa2_q, la2_q;
  logic signed [DW-1:0]       diff;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PW-1:0]       prod_d, prod_q;
  logic signed [SW-1:0]       shifted, sat;
  out_t                       res_q;

  assign diff    = DW'(sa1_q) - DW'(zero_q);
  assign gain_s  = $signed({1'b0, gain_i});
  assign prod_d  = diff * gain_s;
  // Arithmetic shift floors toward minus infinity
  assign shifted = SW'(prod_q >>> 16);

  always_comb begin
    sat = shifted;
    if (shifted > W_MAX) begin
      sat = W_MAX;
    end else if (shifted < W_MIN) begin
      sat = W_MIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      v1_q <= ctl_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
      // Tare takes effect before this beat's own weight is formed
      if (ctl_i.vld && ctl_i.kind == KIND_TARE) begin
        zero_q <= long_avg_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sa1_q  <= short_avg_i;
    la1_q  <= long_avg_i;
    sa2_q  <= sa1_q;
    la2_q  <= la1_q;
    prod_q <= prod_d;
    res_q.weight_q8     <= WEIGHT_W'(sat);
    res_q.short_average <= sa2_q;
    res_q.long_average  <= la2_q;
  end

  assign vld_o = v3_q;
  assign res_o = res_q;

endmodule

/* hdl/lcat_fifo.sv */
// ----------------------------------------------------------------------------
// lcat_fifo
// Result queue between the data path and the output channel.
// ----------------------------------------------------------------------------
module lcat_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcat_pkg::out_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output lcat_pkg::out_t data_o
);
  import lcat_pkg::*;

  out_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      count_q <= count_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && count_q == (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

/* hdl/load_cell_average_and_tare.sv */
// ----------------------------------------------------------------------------
// load_cell_average_and_tare
// Short and long moving averages of load-cell samples, tare, and tared weight.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------
//   in       | in_valid_i / in_ready_o  | in_data_i  (kind, raw_count)
//   out      | out_valid_o / out_ready_i| out_data_o (weight, averages)
//   config   | cfg_we_i                 | cfg_wdata_i (weight_gain)
//
// One beat per cycle sustained while out_ready_i keeps the queue draining. The
// pace is set by the window memories: read at accept, write back in the next
// cycle, with forwarding when the next beat hits the same slot.
// Reset clears the window valid bits at once; no clearing pass is needed.
// Up to FIFO_DEPTH beats may be outstanding; in_ready_o drops only then.
// ----------------------------------------------------------------------------
module load_cell_average_and_tare #(
  parameter int unsigned SHORT_LEN = lcat_pkg::SHORT_LEN_DEF,
  parameter int unsigned LONG_LEN  = lcat_pkg::LONG_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lcat_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lcat_pkg::out_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic [lcat_pkg::GAIN_W-1:0] cfg_wdata_i
);
  import lcat_pkg::*;

  localparam int unsigned S_TW    = total_width(SHORT_LEN);
  localparam int unsigned L_TW    = total_width(LONG_LEN);
  localparam int unsigned DLY_LEN = CDIV_LAT + 2;
  localparam int unsigned CW      = $clog2(FIFO_DEPTH + 1);

  logic                       in_acc, out_acc, smp_wr;
  logic [GAIN_W-1:0]          gain_q;
  logic [CW-1:0]              inflight_q;
  pipe_t                      dly_q [DLY_LEN];
  logic signed [S_TW-1:0]     short_total;
  logic signed [L_TW-1:0]     long_total;
  logic signed [SAMPLE_W-1:0] short_avg, long_avg;
  logic                       res_vld;
  out_t                       res;

  assign in_ready_o = (inflight_q < CW'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign smp_wr     = in_acc && (in_data_i.kind == KIND_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= GAIN_RESET;
      inflight_q <= '0;
      for (int i = 0; i < DLY_LEN; i++) begin
        dly_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      inflight_q <= inflight_q + CW'(in_acc) - CW'(out_acc);
      // Advance control alongside the windows and dividers
      dly_q[0].vld  <= in_acc;
      dly_q[0].kind <= in_data_i.kind;
      for (int i = 1; i < DLY_LEN; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  lcat_ring #(.LEN(SHORT_LEN)) u_short_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (smp_wr),
    .sample_i (in_data_i.raw_count),
    .total_o  (short_total)
  );

  lcat_ring #(.LEN(LONG_LEN)) u_long_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (smp_wr),
    .sample_i (in_data_i.raw_count),
    .total_o  (long_total)
  );

  lcat_cdiv #(.LEN(SHORT_LEN)) u_short_div (
    .clk_i   (clk_i),
    .total_i (short_total),
    .avg_o   (short_avg)
  );

  lcat_cdiv #(.LEN(LONG_LEN)) u_long_div (
    .clk_i   (clk_i),
    .total_i (long_total),
    .avg_o   (long_avg)
  );

  lcat_weight u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (dly_q[DLY_LEN-1]),
    .short_avg_i (short_avg),
    .long_avg_i  (long_avg),
    .gain_i      (gain_q),
    .vld_o       (res_vld),
    .res_o       (res)
  );

  lcat_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_vld),
    .data_i  (res),
    .pop_i   (out_acc),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CW'(FIFO_DEPTH))
    else $error("outstanding beat count beyond queue depth");

  a_out_needs_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0))
    else $error("result shown with no beat outstanding");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> (inflight_q != '0))
    else $error("result produced with no beat outstanding");

endmodule
